FILE: rtl/core/md5_pkg.sv
// Shared types, constants and round functions of the MD5 digest block.
package md5_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_SLOT  = 6'd56;
    localparam logic [5:0] LAST_SLOT = 6'd63;

    typedef struct packed {
        logic [7:0] data;
        logic       last_byte;
    } md5_byte_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] n;
        logic [3:0] idx;
        n = r[3:0];
        case (r[5:4])
            2'd0:    idx = n;
            2'd1:    idx = 4'(n * 4'd5 + 4'd1);
            2'd2:    idx = 4'(n * 4'd3 + 4'd5);
            2'd3:    idx = 4'(n * 4'd7);
            default: idx = n;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] phase, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

FILE: rtl/core/md5_front.sv
// Front end: takes message items, counts length and generates the padding byte stream.
module md5_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    op,
    input  logic [7:0]              data_byte,
    input  logic                    q_full,
    output logic                    q_push,
    output md5_pkg::md5_byte_t      q_entry
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_ZERO,
        F_LEN
    } front_state_t;

    front_state_t state_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  count_reg;
    logic [63:0]  len_reg;
    logic         take;

    always_comb
    begin
        full = (state_reg != F_IDLE) || q_full;
        take = push && !full;
        q_push = 1'b0;
        q_entry.data = 8'h00;
        q_entry.last_byte = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                q_push = take;
                q_entry.data = (op == md5_pkg::OP_FINISH) ? md5_pkg::PAD_MARK : data_byte;
            end
            F_ZERO:
            begin
                q_push = !q_full && (fill_reg != md5_pkg::LEN_SLOT);
            end
            F_LEN:
            begin
                // length goes out little endian, slot 56 carries the low byte
                q_push = !q_full;
                q_entry.data = len_reg[{fill_reg[2:0], 3'b000} +: 8];
                q_entry.last_byte = (fill_reg == md5_pkg::LAST_SLOT);
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fill_reg  <= '0;
            count_reg <= '0;
            len_reg   <= '0;
        end
        else
        begin
            if (q_push)
                fill_reg <= fill_reg + 6'd1;
            case (state_reg)
                F_IDLE:
                begin
                    if (take)
                    begin
                        if (op == md5_pkg::OP_FINISH)
                        begin
                            len_reg   <= {count_reg, 3'b000};
                            count_reg <= '0;
                            state_reg <= F_ZERO;
                        end
                        else
                        begin
                            count_reg <= count_reg + 61'd1;
                        end
                    end
                end
                F_ZERO:
                begin
                    if (fill_reg == md5_pkg::LEN_SLOT)
                        state_reg <= F_LEN;
                end
                F_LEN:
                begin
                    if (q_push && q_entry.last_byte)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/md5_fifo.sv
// Byte queue between the front end and the compression engine.
module md5_fifo #(
    parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr,
    input  md5_pkg::md5_byte_t      wr_entry,
    output logic                    full,
    input  logic                    rd,
    output md5_pkg::md5_byte_t      rd_entry,
    output logic                    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    md5_pkg::md5_byte_t entries [DEPTH];
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               wr_en;
    logic               rd_en;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign wr_en    = wr && !full;
    assign rd_en    = rd && !empty;
    assign rd_entry = entries[head_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries[tail_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                tail_reg <= (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
            if (rd_en)
                head_reg <= (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + CNT_W'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: rtl/core/md5_back.sv
// Back end: block buffer, one-round-per-cycle compression and the digest output stage.
module md5_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  md5_pkg::md5_byte_t      q_entry,
    output logic                    empty,
    input  logic                    pop,
    output logic [31:0]             digest_word,
    output logic [1:0]              word_index,
    output logic                    last_word
);

    typedef enum logic [1:0] {
        B_LOAD,
        B_PREP,
        B_ROUND,
        B_SUM
    } back_state_t;

    back_state_t state_reg;
    logic [5:0]  byte_cnt_reg;
    logic [23:0] acc_reg;
    logic        final_reg;
    logic [5:0]  round_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] c_reg;
    logic [31:0] d_reg;
    logic [31:0] chain_reg [4];
    logic [31:0] dig_reg [4];
    logic [1:0]  idx_reg;
    logic        dig_valid_reg;

    logic [31:0] wmem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;
    logic        mem_we;
    logic [31:0] wr_word;

    logic [31:0] f_val;
    logic [31:0] tmp_val;
    logic [31:0] b_new;
    logic [31:0] sum_val [4];

    always_comb
    begin
        q_pop   = (state_reg == B_LOAD) && !q_empty;
        mem_we  = q_pop && (byte_cnt_reg[1:0] == 2'd3);
        wr_word = {q_entry.data, acc_reg};
        // fetch one round ahead: the read data is registered
        rd_addr = md5_pkg::msg_index((state_reg == B_ROUND) ? round_reg + 6'd1 : 6'd0);
        f_val   = md5_pkg::round_f(round_reg[5:4], b_reg, c_reg, d_reg);
        tmp_val = a_reg + f_val + rd_data_reg + md5_pkg::ROUND_K[round_reg];
        b_new   = b_reg + md5_pkg::rotl(tmp_val,
                                        md5_pkg::ROT_AMT[{round_reg[5:4], round_reg[1:0]}]);
        sum_val[0] = chain_reg[0] + a_reg;
        sum_val[1] = chain_reg[1] + b_reg;
        sum_val[2] = chain_reg[2] + c_reg;
        sum_val[3] = chain_reg[3] + d_reg;
    end

    assign empty       = !dig_valid_reg;
    assign digest_word = dig_reg[0];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            wmem[byte_cnt_reg[5:2]] <= wr_word;
        rd_data_reg <= wmem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_LOAD;
            byte_cnt_reg  <= '0;
            acc_reg       <= '0;
            final_reg     <= 1'b0;
            round_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            chain_reg[0]  <= md5_pkg::IV_A;
            chain_reg[1]  <= md5_pkg::IV_B;
            chain_reg[2]  <= md5_pkg::IV_C;
            chain_reg[3]  <= md5_pkg::IV_D;
            dig_reg[0]    <= '0;
            dig_reg[1]    <= '0;
            dig_reg[2]    <= '0;
            dig_reg[3]    <= '0;
            idx_reg       <= '0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            // digest words leave through dig_reg[0], one per transfer
            if (pop && dig_valid_reg)
            begin
                dig_reg[0] <= dig_reg[1];
                dig_reg[1] <= dig_reg[2];
                dig_reg[2] <= dig_reg[3];
                idx_reg    <= idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                    dig_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_LOAD:
                begin
                    if (q_pop)
                    begin
                        acc_reg      <= {q_entry.data, acc_reg[23:8]};
                        byte_cnt_reg <= byte_cnt_reg + 6'd1;
                        if (q_entry.last_byte)
                            final_reg <= 1'b1;
                        if (byte_cnt_reg == md5_pkg::LAST_SLOT)
                        begin
                            a_reg     <= chain_reg[0];
                            b_reg     <= chain_reg[1];
                            c_reg     <= chain_reg[2];
                            d_reg     <= chain_reg[3];
                            state_reg <= B_PREP;
                        end
                    end
                end
                B_PREP:
                begin
                    round_reg <= '0;
                    state_reg <= B_ROUND;
                end
                B_ROUND:
                begin
                    a_reg     <= d_reg;
                    d_reg     <= c_reg;
                    c_reg     <= b_reg;
                    b_reg     <= b_new;
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                        state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    if (!final_reg)
                    begin
                        chain_reg[0] <= sum_val[0];
                        chain_reg[1] <= sum_val[1];
                        chain_reg[2] <= sum_val[2];
                        chain_reg[3] <= sum_val[3];
                        state_reg    <= B_LOAD;
                    end
                    else if (!dig_valid_reg)
                    begin
                        // message done: hand off digest, restart the chain
                        dig_reg[0]    <= sum_val[0];
                        dig_reg[1]    <= sum_val[1];
                        dig_reg[2]    <= sum_val[2];
                        dig_reg[3]    <= sum_val[3];
                        idx_reg       <= '0;
                        dig_valid_reg <= 1'b1;
                        chain_reg[0]  <= md5_pkg::IV_A;
                        chain_reg[1]  <= md5_pkg::IV_B;
                        chain_reg[2]  <= md5_pkg::IV_C;
                        chain_reg[3]  <= md5_pkg::IV_D;
                        final_reg     <= 1'b0;
                        state_reg     <= B_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= B_LOAD;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/md5_message_digest.sv
// MD5 digest engine: byte in, four digest words out per message.
// Flow: each 64-byte block is loaded byte by byte while the queue has bytes, then goes
// through one fetch, 64 rounds of the single round unit and one chaining add; no new
// bytes are taken until that block is done. A finish item yields padding bytes up to
// the block end, then one block compression, after which the first digest word shows.
// Reset (rst_n, asynchronous): queue emptied, length and fill cleared, chain set to IV.
module md5_message_digest #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);

    logic               fq_push;
    logic               fq_full;
    logic               fq_pop;
    logic               fq_empty;
    md5_pkg::md5_byte_t fq_wr_entry;
    md5_pkg::md5_byte_t fq_rd_entry;

    md5_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .data_byte (data_byte),
        .q_full    (fq_full),
        .q_push    (fq_push),
        .q_entry   (fq_wr_entry)
    );

    md5_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (fq_push),
        .wr_entry (fq_wr_entry),
        .full     (fq_full),
        .rd       (fq_pop),
        .rd_entry (fq_rd_entry),
        .empty    (fq_empty)
    );

    md5_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (fq_empty),
        .q_pop       (fq_pop),
        .q_entry     (fq_rd_entry),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

FILE: rtl/core/md5_checker.sv
// Port-level checks of the digest output sequence, bound to the top level.
module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] digest_word,
    input logic [1:0]  word_index,
    input logic        last_word
);

    // a digest always starts with word A
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> (word_index == 2'd0))
        else $error("digest does not start at word A");

    // words of one digest follow back to back in index order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_word) |=>
            (!empty && (word_index == $past(word_index) + 2'd1)))
        else $error("digest word sequence broken");

    // the output goes empty right after the last word's transfer
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last_word) |=> empty)
        else $error("output not empty after last digest word");

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_index)))
        else $error("waiting digest word changed");

endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);
